@@ src/number_identifier_lexer_macros.svh @@
// Assertion helpers for the lexer RTL.
`ifndef NUMBER_IDENTIFIER_LEXER_MACROS_SVH
`define NUMBER_IDENTIFIER_LEXER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define NILEX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nilex: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NILEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nilex: next-cycle check failed");

`else

`define NILEX_ASSERT_NOW(label, clk, rst, ante, cons)
`define NILEX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/nilex_pkg.sv @@
package nilex_pkg;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

   typedef enum logic [2:0] {
      SCAN_START = 3'd0,
      SCAN_IDENT = 3'd1,
      SCAN_INT   = 3'd2,
      SCAN_ZERO  = 3'd3,
      SCAN_POINT = 3'd4,
      SCAN_FRAC  = 3'd5,
      SCAN_ERROR = 3'd6
   } scan_state_type;

   typedef enum logic [2:0] {
      KIND_IDENT = 3'd0,
      KIND_INT   = 3'd1,
      KIND_FLOAT = 3'd2,
      KIND_OP    = 3'd3,
      KIND_ERR   = 3'd4,
      KIND_END   = 3'd5
   } token_kind_type;

   // Outcome of one character: new state and up to two tokens in order.
   typedef struct packed {
      scan_state_type next_state;
      logic [1:0]     count;
      token_kind_type kind0;
      token_kind_type kind1;
   } step_result_type;

   typedef struct packed {
      token_kind_type kind;
      logic           last;
   } rsp_entry_type;

endpackage

@@ src/nilex_stream_if.sv @@
interface nilex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface nilex_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic       last_of_run;

   modport source (output valid, output token_kind, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

@@ src/number_identifier_lexer.sv @@
// channel   | dir | payload                  | transfer when
// ----------+-----+--------------------------+----------------------
// req_chan  | in  | char_byte[7:0]           | valid & ready
// rsp_chan  | out | token_kind[2:0], last    | valid & ready
//
// One character per cycle while req ready is high: a byte is registered,
// classified and stepped in the following cycle, and its zero to two
// tokens are pushed into a four-entry result queue. The queue drains one
// token per cycle while rsp ready is high. req ready needs room for the
// staged byte's tokens plus two more; rsp ready does not feed it.
// Synchronous reset returns the scanner to the start state and empties
// the stage and queue.
`include "number_identifier_lexer_macros.svh"

module number_identifier_lexer (
   input  logic               clock,
   input  logic               reset,
   nilex_req_if.sink          req_chan,
   nilex_rsp_if.source        rsp_chan
);

   logic                       stage_valid_ff;
   logic                       stage_valid_in;
   logic [7:0]                 stage_byte_ff;
   nilex_pkg::scan_state_type  scan_state_ff;
   nilex_pkg::scan_state_type  scan_state_in;
   nilex_pkg::step_result_type step;
   nilex_pkg::rsp_entry_type   queue_ff [4];
   logic [1:0]                 wr_ptr_ff;
   logic [1:0]                 wr_ptr_in;
   logic [1:0]                 rd_ptr_ff;
   logic [1:0]                 rd_ptr_in;
   logic [2:0]                 count_ff;
   logic [2:0]                 count_in;
   logic [1:0]                 push_n;
   logic                       pop;
   logic                       req_xfer;
   nilex_pkg::rsp_entry_type   entry0;
   nilex_pkg::rsp_entry_type   entry1;
   nilex_pkg::rsp_entry_type   head;

   nilex_step u_step (
      .state     (scan_state_ff),
      .char_byte (stage_byte_ff),
      .result    (step)
   );

   assign push_n   = stage_valid_ff ? step.count : 2'd0;
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff + {1'b0, push_n}) <= 3'd2;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign entry0.kind = step.kind0;
   assign entry0.last = (step.count == 2'd1);
   assign entry1.kind = step.kind1;
   assign entry1.last = 1'b1;

   assign head               = queue_ff[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != 3'd0);
   assign rsp_chan.token_kind  = head.kind;
   assign rsp_chan.last_of_run = head.last;

   always_comb begin
      stage_valid_in = req_xfer;
      scan_state_in  = stage_valid_ff ? step.next_state : scan_state_ff;
      wr_ptr_in      = wr_ptr_ff + push_n;
      rd_ptr_in      = rd_ptr_ff + {1'b0, pop};
      count_in       = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         scan_state_ff  <= nilex_pkg::SCAN_START;
         wr_ptr_ff      <= 2'd0;
         rd_ptr_ff      <= 2'd0;
         count_ff       <= 3'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         scan_state_ff  <= scan_state_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_byte_ff <= req_chan.char_byte;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= entry0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= entry1;
      end
   end

   `NILEX_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= 3'd4)
   `NILEX_ASSERT_NOW(a_pair_complete, clock, reset, rsp_chan.valid && !rsp_chan.last_of_run, count_ff >= 3'd2)
   `NILEX_ASSERT_NEXT(a_count_holds, clock, reset, !stage_valid_ff && !pop, count_ff == $past(count_ff))
   `NILEX_ASSERT_NEXT(a_ptr_track, clock, reset, req_xfer && count_ff == 3'd0 && !stage_valid_ff, rd_ptr_ff == wr_ptr_ff)

endmodule

@@ src/nilex_step.sv @@
module nilex_step (
   input  nilex_pkg::scan_state_type  state,
   input  logic [7:0]                 char_byte,
   output nilex_pkg::step_result_type result
);

   logic                      is_letter;
   logic                      is_digit;
   logic                      is_nz_digit;
   logic                      is_op;
   nilex_pkg::scan_state_type fresh_state;
   logic                      fresh_emit;
   nilex_pkg::token_kind_type fresh_kind;

   assign is_letter = ((char_byte >= nilex_pkg::CHAR_LC_A) && (char_byte <= nilex_pkg::CHAR_LC_Z))
                   || ((char_byte >= nilex_pkg::CHAR_UC_A) && (char_byte <= nilex_pkg::CHAR_UC_Z));
   assign is_digit    = (char_byte >= nilex_pkg::CHAR_ZERO) && (char_byte <= nilex_pkg::CHAR_NINE);
   assign is_nz_digit = (char_byte >= nilex_pkg::CHAR_ONE) && (char_byte <= nilex_pkg::CHAR_NINE);
   assign is_op = (char_byte == nilex_pkg::CHAR_PLUS) || (char_byte == nilex_pkg::CHAR_MINUS)
               || (char_byte == nilex_pkg::CHAR_STAR) || (char_byte == nilex_pkg::CHAR_SLASH);

   // How the character would be taken from the start state.
   always_comb begin
      fresh_emit = 1'b0;
      fresh_kind = nilex_pkg::KIND_OP;
      if (is_letter) begin
         fresh_state = nilex_pkg::SCAN_IDENT;
      end else if (is_nz_digit) begin
         fresh_state = nilex_pkg::SCAN_INT;
      end else if (char_byte == nilex_pkg::CHAR_ZERO) begin
         fresh_state = nilex_pkg::SCAN_ZERO;
      end else if (is_op) begin
         fresh_state = nilex_pkg::SCAN_START;
         fresh_emit  = 1'b1;
      end else begin
         fresh_state = nilex_pkg::SCAN_ERROR;
         fresh_emit  = 1'b1;
         fresh_kind  = nilex_pkg::KIND_ERR;
      end
   end

   always_comb begin
      result.next_state = state;
      result.count      = 2'd0;
      result.kind0      = nilex_pkg::KIND_END;
      result.kind1      = nilex_pkg::KIND_END;
      if (char_byte == nilex_pkg::CHAR_HASH) begin
         // Flush the pending token, if any, then the end marker.
         result.next_state = nilex_pkg::SCAN_START;
         result.count      = 2'd2;
         unique case (state) inside
            nilex_pkg::SCAN_IDENT: result.kind0 = nilex_pkg::KIND_IDENT;
            nilex_pkg::SCAN_INT:   result.kind0 = nilex_pkg::KIND_INT;
            nilex_pkg::SCAN_FRAC:  result.kind0 = nilex_pkg::KIND_FLOAT;
            nilex_pkg::SCAN_ZERO,
            nilex_pkg::SCAN_POINT: result.kind0 = nilex_pkg::KIND_ERR;
            default:               result.count = 2'd1;
         endcase
      end else begin
         unique case (state)
            nilex_pkg::SCAN_START: begin
               result.next_state = fresh_state;
               result.count      = {1'b0, fresh_emit};
               result.kind0      = fresh_kind;
            end
            nilex_pkg::SCAN_IDENT: begin
               if (!(is_letter || is_digit)) begin
                  result.next_state = fresh_state;
                  result.count      = fresh_emit ? 2'd2 : 2'd1;
                  result.kind0      = nilex_pkg::KIND_IDENT;
                  result.kind1      = fresh_kind;
               end
            end
            nilex_pkg::SCAN_INT: begin
               if (char_byte == nilex_pkg::CHAR_POINT) begin
                  result.next_state = nilex_pkg::SCAN_POINT;
               end else if (!is_digit) begin
                  result.next_state = fresh_state;
                  result.count      = fresh_emit ? 2'd2 : 2'd1;
                  result.kind0      = nilex_pkg::KIND_INT;
                  result.kind1      = fresh_kind;
               end
            end
            nilex_pkg::SCAN_ZERO: begin
               if (char_byte == nilex_pkg::CHAR_POINT) begin
                  result.next_state = nilex_pkg::SCAN_POINT;
               end else begin
                  result.next_state = nilex_pkg::SCAN_ERROR;
                  result.count      = 2'd1;
                  result.kind0      = nilex_pkg::KIND_ERR;
               end
            end
            nilex_pkg::SCAN_POINT: begin
               if (is_digit) begin
                  result.next_state = nilex_pkg::SCAN_FRAC;
               end else begin
                  result.next_state = nilex_pkg::SCAN_ERROR;
                  result.count      = 2'd1;
                  result.kind0      = nilex_pkg::KIND_ERR;
               end
            end
            nilex_pkg::SCAN_FRAC: begin
               if (!is_digit) begin
                  result.next_state = fresh_state;
                  result.count      = fresh_emit ? 2'd2 : 2'd1;
                  result.kind0      = nilex_pkg::KIND_FLOAT;
                  result.kind1      = fresh_kind;
               end
            end
            default: begin
               // error state (and the unused code) swallows input
               result.next_state = nilex_pkg::SCAN_ERROR;
            end
         endcase
      end
   end

endmodule
